FILE: hdl/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, character codes and the sextet-to-character mapping for the
// base64 encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

  localparam logic [6:0] CharUpperA = 7'd65;
  localparam logic [6:0] CharLowerA = 7'd97;
  localparam logic [6:0] CharZero   = 7'd48;
  localparam logic [6:0] CharPlus   = 7'd43;
  localparam logic [6:0] CharSlash  = 7'd47;
  localparam logic [6:0] CharPad    = 7'd61;

  // bytes held in one group
  localparam logic [1:0] CountOne  = 2'd1;
  localparam logic [1:0] CountTwo  = 2'd2;
  localparam logic [1:0] CountFull = 2'd3;

  // one group handed from the front to the back
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] count;
    logic       final_grp;
  } group_t;

  function automatic logic [6:0] sextet_char(input logic [5:0] v);
    logic [6:0] c;
    c = CharSlash;
    if (v < 6'd26) begin
      c = CharUpperA + {1'b0, v};
    end else if (v < 6'd52) begin
      c = CharLowerA + {1'b0, v} - 7'd26;
    end else if (v < 6'd62) begin
      c = CharZero + {1'b0, v} - 7'd52;
    end else if (v == 6'd62) begin
      c = CharPlus;
    end
    return c;
  endfunction

endpackage

FILE: hdl/base64_encoder.sv
// ----------------------------------------------------------------------------
// base64_encoder
// Base64 encoder with pad characters, one byte in and one character out.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while the group queue has room; every third
// byte, or a byte marked final, closes a group of four characters. The output
// port sends one character per cycle while out_stall_i is low, so the
// sustained byte rate is set by the single-character output register. The
// queue holds QueueDepth groups so that input and output can stall
// independently. A final group of one or two bytes ends in two or one '='
// characters and its fourth character carries out_last_o.
module base64_encoder #(
  parameter int QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       final_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [6:0] out_char_o,
  output logic       out_last_o
);
  import b64e_pkg::*;

  group_t push_data, pop_data;
  logic   push, pop, full, empty;

  b64e_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .q_full_i     (full),
    .q_push_o     (push),
    .q_data_o     (push_data)
  );

  b64e_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (pop_data)
  );

  b64e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (empty),
    .q_data_i    (pop_data),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_char_o  (out_char_o),
    .out_last_o  (out_last_o)
  );

endmodule

FILE: hdl/b64e_front.sv
// ----------------------------------------------------------------------------
// b64e_front
// Accepts input bytes, gathers them into groups of up to three and pushes a
// finished or final group into the queue.
// ----------------------------------------------------------------------------
module b64e_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      data_byte_i,
  input  logic            final_byte_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output b64e_pkg::group_t q_data_o
);
  import b64e_pkg::*;

  localparam logic [1:0] PhaseEmpty = 2'd0;
  localparam logic [1:0] PhaseOne   = 2'd1;
  localparam logic [1:0] PhaseTwo   = 2'd2;

  logic [1:0] phase_q, phase_d;
  logic [7:0] h0_q, h0_d, h1_q, h1_d;
  logic       accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    phase_d            = phase_q;
    h0_d               = h0_q;
    h1_d               = h1_q;
    q_push_o           = 1'b0;
    q_data_o.b0        = data_byte_i;
    q_data_o.b1        = 8'd0;
    q_data_o.b2        = 8'd0;
    q_data_o.count     = CountOne;
    q_data_o.final_grp = 1'b1;
    unique case (phase_q)
      PhaseOne: begin
        q_data_o.b0    = h0_q;
        q_data_o.b1    = data_byte_i;
        q_data_o.count = CountTwo;
        if (accept) begin
          if (final_byte_i) begin
            q_push_o = 1'b1;
            phase_d  = PhaseEmpty;
          end else begin
            h1_d    = data_byte_i;
            phase_d = PhaseTwo;
          end
        end
      end
      PhaseTwo: begin
        q_data_o.b0        = h0_q;
        q_data_o.b1        = h1_q;
        q_data_o.b2        = data_byte_i;
        q_data_o.count     = CountFull;
        q_data_o.final_grp = final_byte_i;
        if (accept) begin
          q_push_o = 1'b1;
          phase_d  = PhaseEmpty;
        end
      end
      default: begin
        // empty group; the unused code behaves the same
        if (accept) begin
          if (final_byte_i) begin
            q_push_o = 1'b1;
            phase_d  = PhaseEmpty;
          end else begin
            h0_d    = data_byte_i;
            phase_d = PhaseOne;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhaseEmpty;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h0_q <= h0_d;
    h1_q <= h1_d;
  end

endmodule

FILE: hdl/b64e_queue.sv
// ----------------------------------------------------------------------------
// b64e_queue
// Short group queue between the front and the back of the encoder.
// ----------------------------------------------------------------------------
module b64e_queue #(
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  b64e_pkg::group_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output b64e_pkg::group_t pop_data_o
);
  import b64e_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  group_t          mem_q [Depth];
  logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   cnt_q;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == CW'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: hdl/b64e_back.sv
// ----------------------------------------------------------------------------
// b64e_back
// Takes groups from the queue and sends their four characters, one per
// transfer, through an output register.
// ----------------------------------------------------------------------------
module b64e_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  b64e_pkg::group_t q_data_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [6:0]       out_char_o,
  output logic             out_last_o
);
  import b64e_pkg::*;

  group_t     grp_q;
  logic       grp_valid_q;
  logic [1:0] pos_q;
  logic       out_valid_q;
  logic [6:0] out_char_q;
  logic       out_last_q;
  logic       load;
  logic       grp_done;
  logic [5:0] sextet;
  logic [6:0] next_char;
  logic       next_last;

  // output register is free when empty or being taken this cycle
  assign load     = grp_valid_q && (!out_valid_q || !out_stall_i);
  assign grp_done = load && (pos_q == 2'd3);
  assign q_pop_o  = !q_empty_i && (!grp_valid_q || grp_done);

  always_comb begin
    case (pos_q)
      2'd0:    sextet = grp_q.b0[7:2];
      2'd1:    sextet = {grp_q.b0[1:0], grp_q.b1[7:4]};
      2'd2:    sextet = {grp_q.b1[3:0], grp_q.b2[7:6]};
      default: sextet = grp_q.b2[5:0];
    endcase
    next_char = sextet_char(sextet);
    if ((pos_q == 2'd3) && (grp_q.count != CountFull)) begin
      next_char = CharPad;
    end
    if ((pos_q == 2'd2) && (grp_q.count == CountOne)) begin
      next_char = CharPad;
    end
    next_last = grp_q.final_grp && (pos_q == 2'd3);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_valid_q <= 1'b0;
      pos_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        grp_valid_q <= 1'b1;
        pos_q       <= 2'd0;
      end else if (grp_done) begin
        grp_valid_q <= 1'b0;
        pos_q       <= 2'd0;
      end else if (load) begin
        pos_q <= pos_q + 2'd1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      grp_q <= q_data_i;
    end
    if (load) begin
      out_char_q <= next_char;
      out_last_q <= next_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

endmodule

FILE: hdl/b64e_checker.sv
// ----------------------------------------------------------------------------
// b64e_checker
// Port-level checks for the base64 encoder, bound to the top level.
// ----------------------------------------------------------------------------
module b64e_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] data_byte_i,
  input logic       final_byte_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [6:0] out_char_o,
  input logic       out_last_o
);
  import b64e_pkg::*;

  // a stalled input byte stays offered and unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=>
      in_valid_i && $stable(data_byte_i) && $stable(final_byte_i))
    else $error("input transfer changed while stalled");

  // a stalled character stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  // no character right after reset
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

  // only alphabet characters or pad leave the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((out_char_o >= CharUpperA) && (out_char_o <= CharUpperA + 7'd25)) ||
      ((out_char_o >= CharLowerA) && (out_char_o <= CharLowerA + 7'd25)) ||
      ((out_char_o >= CharZero) && (out_char_o <= CharZero + 7'd9)) ||
      (out_char_o == CharPlus) || (out_char_o == CharSlash) ||
      (out_char_o == CharPad))
    else $error("illegal output character");

  // after a pad transfer that is not last, the next offered character is a pad
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && (out_char_o == CharPad) && !out_last_o
      |=> !out_valid_o || (out_char_o == CharPad))
    else $error("pad not followed by pad");

endmodule

bind base64_encoder b64e_checker u_b64e_checker (.*);

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// base64_encoder testbench
// Streams byte strings into the encoder and checks every output character and
// its last flag against a local base64 encoder that tracks group state. Both
// handshakes idle and stall at random, with one long stretch of full rate.
// ----------------------------------------------------------------------------
module testbench;
  import b64e_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 20;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } b64_char_t;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic [7:0] data_byte_i  = 8'h00;
  logic       final_byte_i = 1'b0;
  logic       out_stall_i  = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [6:0] out_char_o;
  logic       out_last_o;

  // group state of the local encoder
  logic [15:0] held_bytes;
  logic [1:0]  bytes_held;
  b64_char_t   pending_chars[$];
  b64_char_t   want;

  bit send_idle_on = 1'b1;
  bit recv_stall_on = 1'b1;
  int errors;
  int strings_sent;
  int bytes_sent;
  int chars_checked;
  int cycle_count;

  base64_encoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_char_o   (out_char_o),
    .out_last_o   (out_last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d characters still expected",
               cycle_count, pending_chars.size());
      $display("** base64_encoder: FAILED **");
      $finish;
    end
  end

  function automatic logic [6:0] sextet_to_ascii(input logic [5:0] s);
    string alphabet;
    byte   ch;
    alphabet = {"ABCDEFGHIJKLMNOPQRSTUVWXYZ", "abcdefghijklmnopqrstuvwxyz0123456789+/"};
    ch = alphabet[s];
    return ch[6:0];
  endfunction

  task automatic push_group(input logic [7:0] b0, input logic [7:0] b1,
                            input logic [7:0] b2, input logic [1:0] cnt,
                            input logic fin);
    b64_char_t c;
    c.last = 1'b0;
    c.ch = sextet_to_ascii(b0[7:2]);
    pending_chars.push_back(c);
    c.ch = sextet_to_ascii({b0[1:0], b1[7:4]});
    pending_chars.push_back(c);
    c.ch = (cnt < CountTwo) ? CharPad : sextet_to_ascii({b1[3:0], b2[7:6]});
    pending_chars.push_back(c);
    c.ch = (cnt < CountFull) ? CharPad : sextet_to_ascii(b2[5:0]);
    c.last = fin;
    pending_chars.push_back(c);
  endtask

  // advance the local encoder by one accepted byte
  task automatic encode_byte(input logic [7:0] b, input logic fin);
    case (bytes_held)
      2'd1: begin
        if (fin) begin
          push_group(held_bytes[15:8], b, 8'h00, CountTwo, 1'b1);
          held_bytes = '0;
          bytes_held = 2'd0;
        end else begin
          held_bytes = {held_bytes[15:8], b};
          bytes_held = 2'd2;
        end
      end
      2'd2: begin
        push_group(held_bytes[15:8], held_bytes[7:0], b, CountFull, fin);
        held_bytes = '0;
        bytes_held = 2'd0;
      end
      default: begin
        if (fin) begin
          push_group(b, 8'h00, 8'h00, CountOne, 1'b1);
          held_bytes = '0;
          bytes_held = 2'd0;
        end else begin
          held_bytes = {b, 8'h00};
          bytes_held = 2'd1;
        end
      end
    endcase
  endtask

  // one byte transfer; valid stays high afterwards for back-to-back items
  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (send_idle_on) begin
      while ($urandom_range(99) < 36) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i   <= 1'b1;
    data_byte_i  <= b;
    final_byte_i <= fin;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    encode_byte(b, fin);
    bytes_sent++;
    if (fin) strings_sent++;
  endtask

  task automatic send_random_string(input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(255)), i == len - 1);
    end
  endtask

  // output side: random stall, check each transfer against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_stall_i <= recv_stall_on && ($urandom_range(99) < 36);
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        if (pending_chars.size() == 0) begin
          $error("out_char: no character expected, got %0d (last %0b)",
                 out_char_o, out_last_o);
          errors++;
        end else begin
          want = pending_chars.pop_front();
          chars_checked++;
          if (out_char_o !== want.ch) begin
            $error("out_char: expected %0d, got %0d", want.ch, out_char_o);
            errors++;
          end
          if (out_last_o !== want.last) begin
            $error("out_last: expected %0b, got %0b", want.last, out_last_o);
            errors++;
          end
        end
      end
    end
  end

  // one byte: two chars and two pads
  task automatic test_single_byte_strings;
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
  endtask

  // two bytes: three chars and one pad
  task automatic test_two_byte_strings;
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b1);
  endtask

  // final byte closes a complete group, no pad
  task automatic test_full_group_strings;
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // first group is not the last, so its fourth char must not carry the flag
  task automatic test_multi_group_string;
    send_byte(8'hFB, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBE, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h7F, 1'b1);
  endtask

  task automatic test_random_strings(input int byte_target);
    int stop_at;
    stop_at = bytes_sent + byte_target;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(7) == 0) send_random_string($urandom_range(10, 40));
      else send_random_string($urandom_range(1, 9));
    end
  endtask

  // full rate on both sides
  task automatic test_back_to_back(input int byte_target);
    send_idle_on  = 1'b0;
    recv_stall_on = 1'b0;
    test_random_strings(byte_target);
    send_idle_on  = 1'b1;
    recv_stall_on = 1'b1;
  endtask

  initial begin
    held_bytes    = '0;
    bytes_held    = 2'd0;
    errors        = 0;
    strings_sent  = 0;
    bytes_sent    = 0;
    chars_checked = 0;
    cycle_count   = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_byte_strings();
    test_two_byte_strings();
    test_full_group_strings();
    test_multi_group_string();
    test_random_strings(150);
    test_back_to_back(110);
    test_random_strings(130);

    in_valid_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("sent %0d strings (%0d bytes) with random idling and stalls,",
             strings_sent, bytes_sent);
    $display("checked %0d characters incl. all pad cases, %0d mismatches",
             chars_checked, errors);
    if (errors == 0) begin
      $display("** base64_encoder: PASSED **");
    end else begin
      $display("** base64_encoder: FAILED **");
    end
    $finish;
  end

endmodule
